FILE: rtl/core/serial_mode_string_parser_core_assert.svh
// assertion macros for the serial mode string parser
`ifndef SERIAL_MODE_STRING_PARSER_CORE_ASSERT_SVH
`define SERIAL_MODE_STRING_PARSER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// property checked on every clock edge once reset is released
`define SMSP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("smsp assertion failed");

// property that must not hold while reset is released
`define SMSP_ASSERT_NEVER(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
        else $error("smsp forbidden condition");

`else

`define SMSP_ASSERT(lbl, clk, rst_n, prop)

`define SMSP_ASSERT_NEVER(lbl, clk, rst_n, prop)

`endif

`endif

FILE: rtl/core/smsp_pkg.sv
// types and constants for the serial mode string parser
package smsp_pkg;

    localparam int SPEED_BITS_DEF = 24;
    localparam int CHAR_W         = 8;
    localparam int SPEED_W        = 24;
    localparam int LCR_W          = 5;
    localparam int IN_W           = 8;
    localparam int OUT_W          = 32;

    // characters of the mode line
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_ONE   = 8'h31;
    localparam logic [CHAR_W-1:0] CH_TWO   = 8'h32;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_E     = 8'h65;
    localparam logic [CHAR_W-1:0] CH_O     = 8'h6F;
    localparam logic [CHAR_W-1:0] CH_N     = 8'h6E;
    localparam logic [CHAR_W-1:0] CH_H     = 8'h68;
    localparam logic [CHAR_W-1:0] CH_S     = 8'h73;

    // 16550 line-control codes
    localparam logic [LCR_W-1:0] LCR_WORD7    = 5'h02;
    localparam logic [LCR_W-1:0] LCR_WORD8    = 5'h03;
    localparam logic [LCR_W-1:0] LCR_PAR_ODD  = 5'h08;
    localparam logic [LCR_W-1:0] LCR_PAR_EVEN = 5'h18;
    localparam logic [LCR_W-1:0] LCR_STOP2    = 5'h04;

    typedef enum logic [3:0] {
        PH_SPEED      = 4'd0,
        PH_SPEED_SIGN = 4'd1,
        PH_BITS       = 4'd2,
        PH_BITS_SIGN  = 4'd3,
        PH_PARITY     = 4'd4,
        PH_COMMA_A    = 4'd5,
        PH_STOP       = 4'd6,
        PH_COMMA_B    = 4'd7,
        PH_HAND       = 4'd8,
        PH_END        = 4'd9
    } t_phase;

endpackage

FILE: rtl/core/serial_mode_string_parser_core.sv
// serial mode line parser: speed,bits,parity,stop,handshake to speed and line control
// Takes one character of a mode line per cycle, with no gaps needed between characters.
// Each character accepted before an error updates the parse phase and a times-ten number
// accumulator in the same cycle it is accepted. A NUL ends the line: its result is
// registered into the output register (ok, speed, line-control byte) on the NUL, and the
// parser is back at the start of a new line. Non-NUL characters are taken every cycle; the
// input stalls only while a result is held in the output register and downstream is not ready.
`include "serial_mode_string_parser_core_assert.svh"

module serial_mode_string_parser_core #(
    parameter int SPEED_BITS = smsp_pkg::SPEED_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [smsp_pkg::IN_W-1:0]  s_axis_tdata,  // [7:0] ch
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [smsp_pkg::OUT_W-1:0] m_axis_tdata   // [0] ok, [24:1] speed, [29:25] line_control
);

    localparam int AW      = SPEED_BITS + 1;
    localparam int MW      = AW + 4;
    localparam int SW      = smsp_pkg::SPEED_W;
    localparam int LW      = smsp_pkg::LCR_W;
    localparam int OUT_PAD = smsp_pkg::OUT_W - 1 - SW - LW;

    // parser state
    smsp_pkg::t_phase r_phase, n_phase;
    logic [AW-1:0]    r_acc, n_acc;
    logic             r_saw_digit, n_saw_digit;
    logic             r_saw_prefix, n_saw_prefix;
    logic [SW-1:0]    r_held_speed, n_held_speed;
    logic [LW-1:0]    r_held_ctrl, n_held_ctrl;
    logic             r_failed;
    logic             w_bad;

    // result register
    logic             r_out_valid;
    logic             r_ok;
    logic [SW-1:0]    r_speed;
    logic [LW-1:0]    r_lcr;

    logic [smsp_pkg::CHAR_W-1:0] w_ch;
    logic          w_s_fire, w_nul, w_good;
    logic          w_digit, w_comma, w_blank, w_plus;
    logic          w_num_ph, w_speed_ph, w_sign_ph;
    logic          w_acc_over, w_is7, w_is8, w_mul_over;
    logic [3:0]    w_dval;
    logic [MW-1:0] w_mul;
    logic [AW-1:0] w_acc_step;
    logic [AW+SW-1:0] w_acc_ext;

    assign w_ch     = s_axis_tdata;
    assign w_s_fire = s_axis_tvalid && s_axis_tready;
    assign w_nul    = (w_ch == smsp_pkg::CH_NUL);

    assign s_axis_tready = !r_out_valid || m_axis_tready;

    // character classes
    assign w_digit = (w_ch >= smsp_pkg::CH_ZERO) && (w_ch <= smsp_pkg::CH_NINE);
    assign w_comma = (w_ch == smsp_pkg::CH_COMMA);
    assign w_plus  = (w_ch == smsp_pkg::CH_PLUS);
    assign w_blank = (w_ch == smsp_pkg::CH_SPACE)
                  || ((w_ch >= smsp_pkg::CH_TAB) && (w_ch <= smsp_pkg::CH_CR));
    assign w_dval  = w_ch[3:0];

    assign w_speed_ph = (r_phase == smsp_pkg::PH_SPEED) || (r_phase == smsp_pkg::PH_SPEED_SIGN);
    assign w_sign_ph  = (r_phase == smsp_pkg::PH_SPEED_SIGN) || (r_phase == smsp_pkg::PH_BITS_SIGN);
    assign w_num_ph   = w_speed_ph || (r_phase == smsp_pkg::PH_BITS)
                     || (r_phase == smsp_pkg::PH_BITS_SIGN);

    // acc * 10 + digit, saturating just above the speed limit
    assign w_mul      = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
                      + {{(MW-4){1'b0}}, w_dval};
    assign w_mul_over = |w_mul[MW-1:SPEED_BITS];
    assign w_acc_step = w_mul_over ? {1'b1, {SPEED_BITS{1'b0}}} : w_mul[AW-1:0];

    assign w_acc_over = r_acc[SPEED_BITS];
    assign w_is7      = (r_acc == AW'(7));
    assign w_is8      = (r_acc == AW'(8));
    assign w_acc_ext  = {{SW{1'b0}}, r_acc};

    assign w_good = !r_failed && (r_phase == smsp_pkg::PH_END);

    // next phase and syntax check
    always_comb begin
        n_phase = r_phase;
        w_bad   = 1'b0;
        unique case (r_phase)
            smsp_pkg::PH_SPEED, smsp_pkg::PH_SPEED_SIGN,
            smsp_pkg::PH_BITS, smsp_pkg::PH_BITS_SIGN: begin
                if (w_comma) begin
                    if (r_saw_prefix && !r_saw_digit) begin
                        w_bad = 1'b1;
                    end else if (w_speed_ph) begin
                        if (w_acc_over) w_bad = 1'b1;
                        else            n_phase = smsp_pkg::PH_BITS;
                    end else begin
                        if (w_is7 || w_is8) n_phase = smsp_pkg::PH_PARITY;
                        else                w_bad = 1'b1;
                    end
                end else if (!w_digit) begin
                    priority if (r_saw_digit || w_sign_ph) begin
                        w_bad = 1'b1;
                    end else if (w_plus) begin
                        n_phase = w_speed_ph ? smsp_pkg::PH_SPEED_SIGN
                                             : smsp_pkg::PH_BITS_SIGN;
                    end else begin
                        w_bad = !w_blank;
                    end
                end
            end
            smsp_pkg::PH_PARITY: begin
                if (w_ch == smsp_pkg::CH_E || w_ch == smsp_pkg::CH_O || w_ch == smsp_pkg::CH_N)
                    n_phase = smsp_pkg::PH_COMMA_A;
                else
                    w_bad = 1'b1;
            end
            smsp_pkg::PH_COMMA_A: begin
                if (w_comma) n_phase = smsp_pkg::PH_STOP;
                else         w_bad = 1'b1;
            end
            smsp_pkg::PH_STOP: begin
                if (w_ch == smsp_pkg::CH_ONE || w_ch == smsp_pkg::CH_TWO)
                    n_phase = smsp_pkg::PH_COMMA_B;
                else
                    w_bad = 1'b1;
            end
            smsp_pkg::PH_COMMA_B: begin
                if (w_comma) n_phase = smsp_pkg::PH_HAND;
                else         w_bad = 1'b1;
            end
            smsp_pkg::PH_HAND: begin
                if (w_ch == smsp_pkg::CH_MINUS || w_ch == smsp_pkg::CH_H
                        || w_ch == smsp_pkg::CH_S)
                    n_phase = smsp_pkg::PH_END;
                else
                    w_bad = 1'b1;
            end
            default: begin
                // anything after the handshake character
                w_bad = 1'b1;
            end
        endcase
    end

    // datapath next values; garbage after an error is masked on the result
    always_comb begin
        n_acc        = r_acc;
        n_saw_digit  = r_saw_digit;
        n_saw_prefix = r_saw_prefix;
        n_held_speed = r_held_speed;
        n_held_ctrl  = r_held_ctrl;
        if (w_num_ph) begin
            priority if (w_digit) begin
                n_acc       = w_acc_step;
                n_saw_digit = 1'b1;
            end else if (w_comma) begin
                n_acc        = '0;
                n_saw_digit  = 1'b0;
                n_saw_prefix = 1'b0;
                if (w_speed_ph) n_held_speed = w_acc_ext[SW-1:0];
                else            n_held_ctrl  = w_is7 ? smsp_pkg::LCR_WORD7 : smsp_pkg::LCR_WORD8;
            end else begin
                n_saw_prefix = r_saw_prefix || w_blank || w_plus;
            end
        end else if (r_phase == smsp_pkg::PH_PARITY) begin
            if (w_ch == smsp_pkg::CH_E)      n_held_ctrl = r_held_ctrl | smsp_pkg::LCR_PAR_EVEN;
            else if (w_ch == smsp_pkg::CH_O) n_held_ctrl = r_held_ctrl | smsp_pkg::LCR_PAR_ODD;
        end else if (r_phase == smsp_pkg::PH_STOP) begin
            if (w_ch == smsp_pkg::CH_TWO) n_held_ctrl = r_held_ctrl | smsp_pkg::LCR_STOP2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= smsp_pkg::PH_SPEED;
            r_acc        <= '0;
            r_saw_digit  <= 1'b0;
            r_saw_prefix <= 1'b0;
            r_held_speed <= '0;
            r_held_ctrl  <= '0;
            r_failed     <= 1'b0;
        end else if (w_s_fire) begin
            if (w_nul) begin
                // line done, start over
                r_phase      <= smsp_pkg::PH_SPEED;
                r_acc        <= '0;
                r_saw_digit  <= 1'b0;
                r_saw_prefix <= 1'b0;
                r_held_speed <= '0;
                r_held_ctrl  <= '0;
                r_failed     <= 1'b0;
            end else if (!r_failed) begin
                r_phase      <= n_phase;
                r_acc        <= n_acc;
                r_saw_digit  <= n_saw_digit;
                r_saw_prefix <= n_saw_prefix;
                r_held_speed <= n_held_speed;
                r_held_ctrl  <= n_held_ctrl;
                r_failed     <= w_bad;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_ok        <= 1'b0;
            r_speed     <= '0;
            r_lcr       <= '0;
        end else if (w_s_fire && w_nul) begin
            r_out_valid <= 1'b1;
            r_ok        <= w_good;
            r_speed     <= w_good ? r_held_speed : '0;
            r_lcr       <= w_good ? r_held_ctrl : '0;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{OUT_PAD{1'b0}}, r_lcr, r_speed, r_ok};

    `SMSP_ASSERT(a_nul_gives_result, i_clk, i_rst_n, (w_s_fire && w_nul) |=> r_out_valid)
    `SMSP_ASSERT(a_nul_restarts, i_clk, i_rst_n, (w_s_fire && w_nul) |=> !r_failed)
    `SMSP_ASSERT_NEVER(a_no_overwrite, i_clk, i_rst_n, r_out_valid && !m_axis_tready && w_s_fire)
    `SMSP_ASSERT(a_fail_zeroes, i_clk, i_rst_n, (r_out_valid && !r_ok) |-> (r_speed == '0 && r_lcr == '0))
    `SMSP_ASSERT(a_ok_word_len, i_clk, i_rst_n, (r_out_valid && r_ok) |-> r_lcr[1])
    `SMSP_ASSERT(a_fail_sticky, i_clk, i_rst_n, (r_failed && !(w_s_fire && w_nul)) |=> r_failed)

endmodule
